[sv/dcr_pkg.sv]
// dcr_pkg: word types and fixed widths for the disc collision response unit
`timescale 1ns / 1ps
`default_nettype none
package dcr_pkg;

	// one disc pair going in
	typedef struct packed {
		logic signed [15:0] self_pos_x;
		logic signed [15:0] self_pos_y;
		logic signed [15:0] self_vel_x;
		logic signed [15:0] self_vel_y;
		logic        [11:0] self_radius;
		logic signed [15:0] other_pos_x;
		logic signed [15:0] other_pos_y;
		logic signed [15:0] other_vel_x;
		logic signed [15:0] other_vel_y;
		logic        [11:0] other_radius;
		logic        [15:0] damping;
	} pair_t;

	// one contact response coming out
	typedef struct packed {
		logic signed [15:0] new_self_vel_x;
		logic signed [15:0] new_self_vel_y;
		logic signed [15:0] new_other_vel_x;
		logic signed [15:0] new_other_vel_y;
		logic signed [15:0] new_self_pos_x;
		logic signed [15:0] new_self_pos_y;
		logic               contact;
		logic               coincident;
	} result_t;

	// projection divider: dot * d * 2^16 / dist2
	localparam int P_DW = 26;
	localparam int P_QW = 34;
	// mass ratio divider: 2 * m * p / (tot * 2^16)
	localparam int T_DW = 41;
	localparam int T_QW = 20;
	// push divider: d * overlap / radius sum
	localparam int Q_DW = 13;
	localparam int Q_QW = 14;
	// square root of dist2 (26 bit radicand)
	localparam int SQ_RW = 13;

	// damping is Q1.15, rounding half
	localparam logic [38:0] DAMP_HALF = 39'd16384;

	// stage that feeds the output register
	localparam int STG_LAST = 68;

endpackage
`default_nettype wire

[sv/dcr_stream_if.sv]
// dcr_stream_if: valid/ready channel carrying one word of type T
`timescale 1ns / 1ps
`default_nettype none
interface dcr_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/dcr_delay.sv]
// dcr_delay: enable-gated shift line that carries side data along the pipeline
`timescale 1ns / 1ps
`default_nettype none
module dcr_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_q [D];

	// shift one place per advancing cycle
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < D; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[D-1];
endmodule
`default_nettype wire

[sv/dcr_div.sv]
// dcr_div: pipelined restoring divider, signed numerator, rounds half away from zero
`timescale 1ns / 1ps
`default_nettype none
module dcr_div #(
	parameter int DW = 13,
	parameter int QW = 14
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW+QW:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [QW:0]   quo
);
	localparam int NW = DW + QW;

	logic [NW:0]   abs_w;
	logic [NW-1:0] mag_s1;
	logic          neg_s1;
	logic [DW-1:0] den_s1;
	logic [NW-1:0] num_s2;
	logic          neg_s2;
	logic [DW-1:0] den_s2;

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic          neg_s [QW];
	logic [DW-1:0] dvs_s [QW];

	logic [DW-1:0] src_rem [QW];
	logic [QW-1:0] src_low [QW];
	logic [DW-1:0] src_den [QW];
	logic          src_neg [QW];
	logic [DW:0]   cur_w   [QW];
	logic          ge_w    [QW];
	logic [DW:0]   dif_w   [QW];

	// magnitude and sign
	assign abs_w = num[NW] ? (NW+1)'(-num) : (NW+1)'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= abs_w[NW-1:0];
			neg_s1 <= num[NW];
			den_s1 <= den;
		end
	end

	// add half the divisor for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= NW'(mag_s1 + {{(NW-DW+1){1'b0}}, den_s1[DW-1:1]});
			neg_s2 <= neg_s1;
			den_s2 <= den_s1;
		end
	end

	// one quotient bit per stage
	always_comb begin
		for (int i = 0; i < QW; i++) begin
			if (i == 0) begin
				src_rem[i] = num_s2[NW-1:QW];
				src_low[i] = num_s2[QW-1:0];
				src_den[i] = den_s2;
				src_neg[i] = neg_s2;
			end else begin
				src_rem[i] = rem_s[i-1];
				src_low[i] = low_s[i-1];
				src_den[i] = dvs_s[i-1];
				src_neg[i] = neg_s[i-1];
			end
			cur_w[i] = {src_rem[i], src_low[i][QW-1]};
			ge_w[i]  = cur_w[i] >= {1'b0, src_den[i]};
			dif_w[i] = cur_w[i] - {1'b0, src_den[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW; i++) begin
				rem_s[i] <= ge_w[i] ? dif_w[i][DW-1:0] : cur_w[i][DW-1:0];
				low_s[i] <= {src_low[i][QW-2:0], ge_w[i]};
				dvs_s[i] <= src_den[i];
				neg_s[i] <= src_neg[i];
			end
		end
	end

	// restore the sign
	assign quo = neg_s[QW-1] ? -$signed({1'b0, low_s[QW-1]}) : $signed({1'b0, low_s[QW-1]});
endmodule
`default_nettype wire

[sv/dcr_sqrt.sv]
// dcr_sqrt: pipelined digit-by-digit integer square root with remainder
`timescale 1ns / 1ps
`default_nettype none
module dcr_sqrt #(
	parameter int RW = 13
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root,
	output logic [RW+1:0]   rem
);
	logic [RW-1:0]   rt_s [RW];
	logic [RW+1:0]   rm_s [RW];
	logic [2*RW-1:0] rd_s [RW];

	logic [RW-1:0]   src_rt [RW];
	logic [RW+1:0]   src_rm [RW];
	logic [2*RW-1:0] src_rd [RW];
	logic [RW+3:0]   cur_w  [RW];
	logic [RW+3:0]   try_w  [RW];
	logic [RW+3:0]   dif_w  [RW];
	logic            ge_w   [RW];

	// bring down two radicand bits per stage
	always_comb begin
		for (int i = 0; i < RW; i++) begin
			if (i == 0) begin
				src_rt[i] = '0;
				src_rm[i] = '0;
				src_rd[i] = rad;
			end else begin
				src_rt[i] = rt_s[i-1];
				src_rm[i] = rm_s[i-1];
				src_rd[i] = rd_s[i-1];
			end
			cur_w[i] = {src_rm[i], src_rd[i][2*RW-1 -: 2]};
			try_w[i] = {2'b00, src_rt[i], 2'b01};
			ge_w[i]  = cur_w[i] >= try_w[i];
			dif_w[i] = cur_w[i] - try_w[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < RW; i++) begin
				rm_s[i] <= ge_w[i] ? dif_w[i][RW+1:0] : cur_w[i][RW+1:0];
				rt_s[i] <= {src_rt[i][RW-2:0], ge_w[i]};
				rd_s[i] <= {src_rd[i][2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = rt_s[RW-1];
	assign rem  = rm_s[RW-1];
endmodule
`default_nettype wire

[sv/disc_collision_response_unit.sv]
// disc_collision_response_unit: pipelined elastic contact response for two discs
//
//   channel  modport  word      meaning
//   pair     sink     pair_t    two discs and a damping factor
//   result   source   result_t  new velocities, pushed first position, flags
//
// One word accepted per cycle while the skid register is empty.
// The pipeline runs the projection divider (36 stages) and the mass ratio divider
// (22 stages) in series; each resolves one quotient bit per stage after its sign and rounding stages.
// arst_n clears the stage valid bits and the output and skid valid flags; data needs no reset.
// A stalled result goes to a skid register; the pipeline freezes only while it is full.
`timescale 1ns / 1ps
`default_nettype none
module disc_collision_response_unit
	import dcr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	dcr_stream_if.sink   pair,
	dcr_stream_if.source result
);
	localparam int P_LAT = P_QW + 2;
	localparam int T_LAT = T_QW + 2;
	localparam int Q_LAT = Q_QW + 2;

	pair_t   in_w;
	logic    en;
	logic [STG_LAST:1] vld_q;

	assign in_w = pair.data;

	// ---------------- front: differences, squares, dot product ----------------
	logic signed [16:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [12:0]        rs_s1;
	logic [11:0]        sr_s1, orr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({in_w.other_pos_x[15], in_w.other_pos_x})
				- $signed({in_w.self_pos_x[15], in_w.self_pos_x});
			dy_s1  <= $signed({in_w.other_pos_y[15], in_w.other_pos_y})
				- $signed({in_w.self_pos_y[15], in_w.self_pos_y});
			dvx_s1 <= $signed({in_w.self_vel_x[15], in_w.self_vel_x})
				- $signed({in_w.other_vel_x[15], in_w.other_vel_x});
			dvy_s1 <= $signed({in_w.self_vel_y[15], in_w.self_vel_y})
				- $signed({in_w.other_vel_y[15], in_w.other_vel_y});
			rs_s1  <= {1'b0, in_w.self_radius} + {1'b0, in_w.other_radius};
			sr_s1  <= in_w.self_radius;
			orr_s1 <= in_w.other_radius;
		end
	end

	// inside contact |d| < 2^13, so 14 bits of d suffice there
	logic signed [13:0] dx14_w, dy14_w;
	logic signed [33:0] dxsq_w, dysq_w;
	logic [32:0]        dx2_s2, dy2_s2;
	logic [25:0]        rs2_s2;
	logic [23:0]        ms_s2, mo_s2;
	logic signed [30:0] pdx_s2, pdy_s2;
	logic signed [13:0] dx14_s2, dy14_s2;
	logic [12:0]        rs_s2;

	assign dx14_w = $signed(dx_s1[13:0]);
	assign dy14_w = $signed(dy_s1[13:0]);
	assign dxsq_w = dx_s1 * dx_s1;
	assign dysq_w = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2  <= dxsq_w[32:0];
			dy2_s2  <= dysq_w[32:0];
			rs2_s2  <= rs_s1 * rs_s1;
			ms_s2   <= sr_s1 * sr_s1;
			mo_s2   <= orr_s1 * orr_s1;
			pdx_s2  <= dvx_s1 * dx14_w;
			pdy_s2  <= dvy_s1 * dy14_w;
			dx14_s2 <= dx14_w;
			dy14_s2 <= dy14_w;
			rs_s2   <= rs_s1;
		end
	end

	logic [33:0]        dist2_s3;
	logic signed [31:0] dot_s3;
	logic [24:0]        tot_s3;
	logic [25:0]        rs2_s3;
	logic [12:0]        rs_s3;
	logic signed [13:0] dx14_s3, dy14_s3;
	logic [23:0]        ms_s3, mo_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dist2_s3 <= {1'b0, dx2_s2} + {1'b0, dy2_s2};
			dot_s3   <= 32'(pdx_s2) + 32'(pdy_s2);
			tot_s3   <= {1'b0, ms_s2} + {1'b0, mo_s2};
			rs2_s3   <= rs2_s2;
			rs_s3    <= rs_s2;
			dx14_s3  <= dx14_s2;
			dy14_s3  <= dy14_s2;
			ms_s3    <= ms_s2;
			mo_s3    <= mo_s2;
		end
	end

	// contact test and projection numerators
	logic               hit_s4, coin_s4;
	logic signed [45:0] num_s4 [2];
	logic [25:0]        dd_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			coin_s4   <= dist2_s3 == '0;
			hit_s4    <= (dist2_s3 != '0) && (dist2_s3 < {8'b0, rs2_s3});
			num_s4[0] <= dot_s3 * dx14_s3;
			num_s4[1] <= dot_s3 * dy14_s3;
			dd_s4     <= dist2_s3[25:0];
		end
	end

	// ---------------- velocity path ----------------
	logic signed [P_QW:0] p_s40 [2];

	for (genvar k = 0; k < 2; k++) begin : g_pdiv
		dcr_div #(.DW(P_DW), .QW(P_QW)) u_pdiv (
			.clk (clk),
			.en  (en),
			.num ({num_s4[k][44:0], 16'b0}),
			.den (dd_s4),
			.quo (p_s40[k])
		);
	end

	logic [47:0] mass_s40;
	logic [24:0] tot_s42;

	dcr_delay #(.W(48), .D(P_LAT + 1)) u_mass_dly (
		.clk (clk), .en (en), .din ({ms_s3, mo_s3}), .dout (mass_s40)
	);
	dcr_delay #(.W(25), .D(P_LAT + 3)) u_tot_dly (
		.clk (clk), .en (en), .din (tot_s3), .dout (tot_s42)
	);

	// lanes: self x, self y use the other mass; other x, other y use the self mass
	logic [23:0]          lane_m [4];
	logic signed [P_QW:0] lane_p [4];

	always_comb begin
		lane_m[0] = mass_s40[23:0];
		lane_m[1] = mass_s40[23:0];
		lane_m[2] = mass_s40[47:24];
		lane_m[3] = mass_s40[47:24];
		lane_p[0] = p_s40[0];
		lane_p[1] = p_s40[1];
		lane_p[2] = p_s40[0];
		lane_p[3] = p_s40[1];
	end

	// mass times projection as two partial products
	logic [40:0]        lo_s41 [4];
	logic signed [42:0] hi_s41 [4];
	logic signed [60:0] msum_w [4];
	logic signed [61:0] tnum_s42 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				lo_s41[k] <= lane_m[k] * lane_p[k][16:0];
				hi_s41[k] <= $signed({1'b0, lane_m[k]}) * $signed(lane_p[k][P_QW:17]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			msum_w[k] = $signed({hi_s41[k][42], hi_s41[k], 17'b0}) + $signed({20'b0, lo_s41[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				tnum_s42[k] <= {msum_w[k], 1'b0};
			end
		end
	end

	logic signed [T_QW:0] term_s64 [4];

	for (genvar k = 0; k < 4; k++) begin : g_tdiv
		dcr_div #(.DW(T_DW), .QW(T_QW)) u_tdiv (
			.clk (clk),
			.en  (en),
			.num (tnum_s42[k]),
			.den ({tot_s42, 16'b0}),
			.quo (term_s64[k])
		);
	end

	// input velocities ride along to the update and to the output
	logic [63:0] vel_s64, vel_s68;
	logic [15:0] damp_s65;

	dcr_delay #(.W(64), .D(P_LAT + T_LAT + 6)) u_vel_dly (
		.clk (clk), .en (en),
		.din ({in_w.self_vel_x, in_w.self_vel_y, in_w.other_vel_x, in_w.other_vel_y}),
		.dout (vel_s64)
	);
	dcr_delay #(.W(64), .D(4)) u_velo_dly (
		.clk (clk), .en (en), .din (vel_s64), .dout (vel_s68)
	);
	dcr_delay #(.W(16), .D(P_LAT + T_LAT + 7)) u_damp_dly (
		.clk (clk), .en (en), .din (in_w.damping), .dout (damp_s65)
	);

	logic signed [15:0] lane_v [4];

	always_comb begin
		lane_v[0] = $signed(vel_s64[63:48]);
		lane_v[1] = $signed(vel_s64[47:32]);
		lane_v[2] = $signed(vel_s64[31:16]);
		lane_v[3] = $signed(vel_s64[15:0]);
	end

	// velocity exchange
	logic signed [21:0] v_s65 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s65[0] <= 22'(lane_v[0]) - 22'(term_s64[0]);
			v_s65[1] <= 22'(lane_v[1]) - 22'(term_s64[1]);
			v_s65[2] <= 22'(lane_v[2]) + 22'(term_s64[2]);
			v_s65[3] <= 22'(lane_v[3]) + 22'(term_s64[3]);
		end
	end

	// damping multiply and rounding shift
	logic signed [38:0] prod_s66 [4];
	logic [38:0]        mag_s67  [4];
	logic               neg_s67  [4];
	logic [38:0]        rnd_w    [4];
	logic [23:0]        r_s68    [4];
	logic               neg_s68  [4];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				prod_s66[k] <= v_s65[k] * $signed({1'b0, damp_s65});
				mag_s67[k]  <= prod_s66[k][38] ? 39'(-prod_s66[k]) : 39'(prod_s66[k]);
				neg_s67[k]  <= prod_s66[k][38];
				r_s68[k]    <= rnd_w[k][38:15];
				neg_s68[k]  <= neg_s67[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd_w[k] = mag_s67[k] + DAMP_HALF;
		end
	end

	// ---------------- push path ----------------
	logic [SQ_RW-1:0] root_s16;
	logic [SQ_RW+1:0] rem_s16;

	dcr_sqrt #(.RW(SQ_RW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (dist2_s3[2*SQ_RW-1:0]),
		.root (root_s16),
		.rem  (rem_s16)
	);

	logic [12:0] rs_s17, rs_s19;
	logic [27:0] dxy_s18;
	logic [13:0] dist_s17;
	logic signed [14:0] ovl_s18;
	logic signed [28:0] numq_s19 [2];

	dcr_delay #(.W(13), .D(SQ_RW + 1)) u_rs17_dly (
		.clk (clk), .en (en), .din (rs_s3), .dout (rs_s17)
	);
	dcr_delay #(.W(13), .D(SQ_RW + 3)) u_rs19_dly (
		.clk (clk), .en (en), .din (rs_s3), .dout (rs_s19)
	);
	dcr_delay #(.W(28), .D(SQ_RW + 2)) u_dxy_dly (
		.clk (clk), .en (en), .din ({dx14_s3, dy14_s3}), .dout (dxy_s18)
	);

	// round the root to nearest, then overlap and its projection
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s17    <= {1'b0, root_s16} + 14'(rem_s16 > {2'b0, root_s16});
			ovl_s18     <= $signed({2'b0, rs_s17}) - $signed({1'b0, dist_s17});
			numq_s19[0] <= $signed(dxy_s18[27:14]) * ovl_s18;
			numq_s19[1] <= $signed(dxy_s18[13:0]) * ovl_s18;
		end
	end

	logic signed [Q_QW:0] push_s35 [2];

	for (genvar k = 0; k < 2; k++) begin : g_qdiv
		dcr_div #(.DW(Q_DW), .QW(Q_QW)) u_qdiv (
			.clk (clk),
			.en  (en),
			.num (numq_s19[k][Q_DW+Q_QW:0]),
			.den (rs_s19),
			.quo (push_s35[k])
		);
	end

	logic [31:0] spos_s35;
	logic        hit_s35;

	dcr_delay #(.W(32), .D(SQ_RW + Q_LAT + 6)) u_spos_dly (
		.clk (clk), .en (en), .din ({in_w.self_pos_x, in_w.self_pos_y}), .dout (spos_s35)
	);
	dcr_delay #(.W(1), .D(SQ_RW + Q_LAT + 2)) u_hit35_dly (
		.clk (clk), .en (en), .din (hit_s4), .dout (hit_s35)
	);

	// pushed position, saturated, or the input position without contact
	logic signed [16:0] pdif_w [2];
	logic [15:0]        pos_s36 [2];

	always_comb begin
		pdif_w[0] = $signed({spos_s35[31], spos_s35[31:16]}) - 17'(push_s35[0]);
		pdif_w[1] = $signed({spos_s35[15], spos_s35[15:0]}) - 17'(push_s35[1]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				if (!hit_s35) begin
					pos_s36[k] <= (k == 0) ? spos_s35[31:16] : spos_s35[15:0];
				end else if (pdif_w[k][16] != pdif_w[k][15]) begin
					pos_s36[k] <= pdif_w[k][16] ? 16'h8000 : 16'h7fff;
				end else begin
					pos_s36[k] <= pdif_w[k][15:0];
				end
			end
		end
	end

	logic [31:0] pos_s68;
	logic [1:0]  flags_s68;

	dcr_delay #(.W(32), .D(STG_LAST - 36)) u_pos_dly (
		.clk (clk), .en (en), .din ({pos_s36[0], pos_s36[1]}), .dout (pos_s68)
	);
	dcr_delay #(.W(2), .D(STG_LAST - 4)) u_flag_dly (
		.clk (clk), .en (en), .din ({hit_s4, coin_s4}), .dout (flags_s68)
	);

	// ---------------- result word ----------------
	function automatic logic [15:0] sat_vel(input logic [23:0] r, input logic neg);
		logic [15:0] res;
		if (!neg) begin
			res = (r > 24'd32767) ? 16'h7fff : r[15:0];
		end else begin
			res = (r > 24'd32768) ? 16'h8000 : 16'(16'd0 - r[15:0]);
		end
		return res;
	endfunction

	result_t res_w;
	logic [15:0] vnew_w [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			vnew_w[k] = flags_s68[1] ? sat_vel(r_s68[k], neg_s68[k]) : vel_s68[63-16*k -: 16];
		end
		res_w.new_self_vel_x  = vnew_w[0];
		res_w.new_self_vel_y  = vnew_w[1];
		res_w.new_other_vel_x = vnew_w[2];
		res_w.new_other_vel_y = vnew_w[3];
		res_w.new_self_pos_x  = pos_s68[31:16];
		res_w.new_self_pos_y  = pos_s68[15:0];
		res_w.contact         = flags_s68[1];
		res_w.coincident      = flags_s68[0];
	end

	// ---------------- valid bits and output skid ----------------
	result_t out_q, skid_q;
	logic    out_vld_q, skid_vld_q;
	logic    take_w, arrive_w;

	assign en       = !skid_vld_q;
	assign take_w   = out_vld_q && result.ready;
	assign arrive_w = en && vld_q[STG_LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STG_LAST-1:1], pair.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take_w) begin
			out_vld_q  <= skid_vld_q || arrive_w;
			skid_vld_q <= 1'b0;
		end else if (arrive_w) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take_w) begin
			out_q <= skid_vld_q ? skid_q : res_w;
		end else if (arrive_w) begin
			skid_q <= res_w;
		end
	end

	assign pair.ready   = en;
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// ---------------- checks ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid word without output word");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.contact && out_q.coincident))
		else $error("contact and coincident both set");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_q[STG_LAST] && out_vld_q && !result.ready))
		else $error("skid filled without a stalled word");

endmodule
`default_nettype wire

[bench/tb_disc_collision_response_unit.sv]
// testbench for the disc collision response unit: random and directed pairs against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_disc_collision_response_unit;
	import dcr_pkg::*;

	logic clk;
	logic arst_n;

	dcr_stream_if #(.T(pair_t))   pair_ch ();
	dcr_stream_if #(.T(result_t)) result_ch ();

	disc_collision_response_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch.sink),
		.result (result_ch.source)
	);

	pair_t   pending_pairs[$];
	result_t expected_responses[$];
	int      mismatches;
	int      idle_cycles;
	bit      stimulus_done;
	bit      hold_sender;
	bit      pair_taken;
	int      send_gap;
	int      recv_gap;
	localparam int WATCHDOG_LIMIT = 20000;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// rounded division, halves away from zero, d > 0
	function automatic longint round_div(longint n, longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	// integer square root rounded to nearest
	function automatic longint isqrt_round(longint n);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
				r = r + (longint'(1) << b);
		end
		if (n - r * r > r) r++;
		return r;
	endfunction

	// contact response of one disc pair
	function automatic result_t collision_response(pair_t p);
		result_t r;
		longint spx, spy, svx, svy, sr, opx, opy, ovx, ovy, orad, dmp;
		longint dx, dy, dist2, rs, ms, mo, totg, dot, px, py;
		longint v1x, v1y, v2x, v2y, dist_rt, ovl;
		spx = p.self_pos_x;   spy = p.self_pos_y;
		svx = p.self_vel_x;   svy = p.self_vel_y;
		sr  = p.self_radius;
		opx = p.other_pos_x;  opy = p.other_pos_y;
		ovx = p.other_vel_x;  ovy = p.other_vel_y;
		orad = p.other_radius;
		dmp = p.damping;
		dx = opx - spx;
		dy = opy - spy;
		dist2 = dx * dx + dy * dy;
		rs = sr + orad;
		r.coincident = (dist2 == 0);
		r.contact = (dist2 != 0) && (dist2 < rs * rs);
		if (r.contact) begin
			ms = sr * sr;
			mo = orad * orad;
			totg = (ms + mo) << 16;
			dot = (svx - ovx) * dx + (svy - ovy) * dy;
			px = round_div(dot * dx * 65536, dist2);
			py = round_div(dot * dy * 65536, dist2);
			v1x = svx - round_div(2 * mo * px, totg);
			v1y = svy - round_div(2 * mo * py, totg);
			v2x = ovx + round_div(2 * ms * px, totg);
			v2y = ovy + round_div(2 * ms * py, totg);
			svx = round_div(v1x * dmp, 32768);
			svy = round_div(v1y * dmp, 32768);
			ovx = round_div(v2x * dmp, 32768);
			ovy = round_div(v2y * dmp, 32768);
			dist_rt = isqrt_round(dist2);
			ovl = rs - dist_rt;
			spx = spx - round_div(dx * ovl, rs);
			spy = spy - round_div(dy * ovl, rs);
		end
		r.new_self_vel_x  = clamp16(svx);
		r.new_self_vel_y  = clamp16(svy);
		r.new_other_vel_x = clamp16(ovx);
		r.new_other_vel_y = clamp16(ovy);
		r.new_self_pos_x  = clamp16(spx);
		r.new_self_pos_y  = clamp16(spy);
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic pair_t random_pair(bit near);
		pair_t p;
		p = pair_t'(168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
		if (near) begin
			// keep centers close so contact is likely
			p.self_radius  = 12'($urandom_range(0, 4095));
			p.other_radius = 12'($urandom_range(0, 4095));
			p.other_pos_x  = p.self_pos_x + 16'($signed($urandom_range(0, 8000)) - 4000);
			p.other_pos_y  = p.self_pos_y + 16'($signed($urandom_range(0, 8000)) - 4000);
			if ($urandom_range(0, 3) != 0) begin
				p.self_pos_x  = 16'($signed($urandom_range(0, 20000)) - 10000);
				p.self_pos_y  = 16'($signed($urandom_range(0, 20000)) - 10000);
				p.other_pos_x = p.self_pos_x + 16'($signed($urandom_range(0, 4000)) - 2000);
				p.other_pos_y = p.self_pos_y + 16'($signed($urandom_range(0, 4000)) - 2000);
			end
			if ($urandom_range(0, 3) != 0) p.damping = 16'($urandom_range(19661, 32768));
		end
		return p;
	endfunction

	function automatic pair_t make_pair(int spx, int spy, int svx, int svy, int sr,
		int opx, int opy, int ovx, int ovy, int orad, int dmp);
		pair_t p;
		p.self_pos_x = 16'(spx);   p.self_pos_y = 16'(spy);
		p.self_vel_x = 16'(svx);   p.self_vel_y = 16'(svy);
		p.self_radius = 12'(sr);
		p.other_pos_x = 16'(opx);  p.other_pos_y = 16'(opy);
		p.other_vel_x = 16'(ovx);  p.other_vel_y = 16'(ovy);
		p.other_radius = 12'(orad);
		p.damping = 16'(dmp);
		return p;
	endfunction

	// stimulus
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		pair_ch.valid = 1'b0;
		pair_ch.data = '0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		pair_taken = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: passthrough, coincident, zero radii, head-on, damping extremes
		pending_pairs.push_back(make_pair(0, 0, 100, -100, 256, 10000, 0, 5, 5, 256, 32768));
		pending_pairs.push_back(make_pair(500, 500, 1, 2, 4095, 500, 500, 3, 4, 4095, 32768));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 1, 0, 0, 0, 0, 32768));
		pending_pairs.push_back(make_pair(0, 0, 256, 0, 256, 300, 0, -256, 0, 256, 32768));
		pending_pairs.push_back(make_pair(0, 0, 256, 0, 256, 300, 0, -256, 0, 256, 0));
		pending_pairs.push_back(make_pair(0, 0, 256, 0, 256, 300, 0, -256, 0, 256, 65535));
		pending_pairs.push_back(make_pair(0, 0, 32767, 32767, 4095, 1, 1, -32768, -32768,
			4095, 65535));
		pending_pairs.push_back(make_pair(-32768, -32768, -32768, 32767, 4095, -32767, -32767,
			32767, -32768, 4095, 65535));
		pending_pairs.push_back(make_pair(32767, 32767, 0, 0, 4095, 32767 - 4000, 32767 - 4000,
			0, 0, 4095, 32768));
		pending_pairs.push_back(make_pair(0, 0, 10, 20, 4095, 100, 200, -30, 40, 0, 32768));
		pending_pairs.push_back(make_pair(0, 0, 10, 20, 0, 100, 200, -30, 40, 4095, 32768));
		pending_pairs.push_back(make_pair(0, 0, 10, 20, 100, 150, 0, -30, 40, 50, 19661));
		pending_pairs.push_back(make_pair(-32768, 0, 0, 0, 4095, 32767, 0, 0, 0, 4095, 32768));
		pending_pairs.push_back(make_pair(100, -100, 500, 0, 300, 100, 200, 0, 0, 300, 32767));

		// let the directed words drain before random traffic
		wait (pending_pairs.size() == 0);
		hold_sender = 1'b1;
		wait (expected_responses.size() == 0);
		hold_sender = 1'b0;

		for (int i = 0; i < 400; i++)
			pending_pairs.push_back(random_pair($urandom_range(0, 4) != 0));
		wait (pending_pairs.size() == 0);
		stimulus_done = 1'b1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pair_ch.valid && pair_taken) begin
				send_gap = pick_gap();
			end
			if (!pair_ch.valid || pair_taken) begin
				if (send_gap > 0 || hold_sender || pending_pairs.size() == 0) begin
					if (send_gap > 0) send_gap--;
					pair_ch.valid <= 1'b0;
				end else begin
					pair_ch.data <= pending_pairs.pop_front();
					pair_ch.valid <= 1'b1;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t got;
		result_t want;
		pair_taken = arst_n && pair_ch.valid && pair_ch.ready;
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready)
				expected_responses.push_back(collision_response(pair_ch.data));
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (expected_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", got);
				end else begin
					want = expected_responses.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch exp/got vel %h/%h %h/%h %h/%h %h/%h",
								want.new_self_vel_x, got.new_self_vel_x,
								want.new_self_vel_y, got.new_self_vel_y,
								want.new_other_vel_x, got.new_other_vel_x,
								want.new_other_vel_y, got.new_other_vel_y);
							$display("  pos %h/%h %h/%h c %b/%b k %b/%b",
								want.new_self_pos_x, got.new_self_pos_x,
								want.new_self_pos_y, got.new_self_pos_y,
								want.contact, got.contact,
								want.coincident, got.coincident);
						end
					end
				end
			end
			// watchdog on acceptance activity
			if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		fork
			begin
				wait (stimulus_done && !pair_ch.valid && expected_responses.size() == 0);
				repeat (STG_LAST + 20) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG_LIMIT);
		join_any
		if (idle_cycles >= WATCHDOG_LIMIT || expected_responses.size() != 0) begin
			$display("tb_disc_collision_response_unit failed");
		end else if (mismatches == 0) begin
			$display("tb_disc_collision_response_unit passed");
		end else begin
			$display("tb_disc_collision_response_unit failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
